// ----- hdl/rmst_pkg.sv -----
package rmst_pkg;

  // tree geometry
  localparam int MaxLeaves = 1024;
  localparam int LEAF_W    = 11;                       // position / leaf_count fields
  localparam int NODE_W    = $clog2(2 * MaxLeaves);    // tree node index
  localparam int WALK_W    = NODE_W + 1;               // query bounds reach 2*MaxLeaves
  localparam int VALUE_W   = 32;

  localparam logic signed [VALUE_W-1:0] MostNeg = {1'b1, {(VALUE_W-1){1'b0}}};

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic [LEAF_W-1:0]         range_low;
    logic [LEAF_W-1:0]         range_high;
    logic [LEAF_W-1:0]         position;
    logic signed [VALUE_W-1:0] new_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] max_value;
    logic                      range_error;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_QUERY,
    OP_UPDATE,
    OP_REJECT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                   op;
    logic [LEAF_W-1:0]         lo;
    logic [LEAF_W-1:0]         hi;
    logic [LEAF_W-1:0]         pos;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // signed maximum
  function automatic logic signed [VALUE_W-1:0] smax(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b
  );
    return (a >= b) ? a : b;
  endfunction

endpackage

// ----- hdl/range_max_segment_tree.sv -----
// Update: in the back end, a leaf write, then one read/write per tree level.
// Query: one result word, a registered one-cycle strobe.
// Rejected query answers in the cycle after it leaves the queue; ignored updates never enter the queue.
// A 2-entry command queue lets start be taken while the back end walks the tree.
// Reset: synchronous; the 2048-entry tree store is swept to the most negative
// value, busy high meanwhile. leaf_count resets to 1024.
module range_max_segment_tree (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  rmst_pkg::in_word_t          item,
  input  logic                        cfg_we,
  input  logic [rmst_pkg::LEAF_W-1:0] cfg_data,
  output rmst_pkg::out_word_t         result,
  output logic                        result_valid
);

  logic           push;
  logic           pop;
  logic           q_valid;
  logic           q_full;
  logic           clearing;
  rmst_pkg::cmd_t push_cmd;
  rmst_pkg::cmd_t head;

  // accept and classify
  rmst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push),
    .cmd      (push_cmd)
  );

  // command queue
  rmst_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .head     (head)
  );

  // tree engine
  rmst_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .clearing     (clearing),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ----- hdl/rmst_front.sv -----
module rmst_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  rmst_pkg::in_word_t          item,
  input  logic                        cfg_we,
  input  logic [rmst_pkg::LEAF_W-1:0] cfg_data,
  input  logic                        q_full,
  input  logic                        clearing,
  output logic                        push,
  output rmst_pkg::cmd_t              cmd
);

  logic [rmst_pkg::LEAF_W-1:0] leaf_count;
  logic [rmst_pkg::LEAF_W-1:0] n_active;
  logic                        accept;
  logic                        pos_ok;
  logic                        range_ok;

  // leaf_count register
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= rmst_pkg::LEAF_W'(1024);
    end else if (cfg_we) begin
      leaf_count <= cfg_data;
    end
  end

  // clamp to tree size
  assign n_active = (leaf_count > rmst_pkg::LEAF_W'(rmst_pkg::MaxLeaves)) ?
                    rmst_pkg::LEAF_W'(rmst_pkg::MaxLeaves) : leaf_count;

  assign busy   = q_full | clearing;
  assign accept = start & ~busy;

  // classify the word
  assign pos_ok   = (item.position != '0) && (item.position <= n_active);
  assign range_ok = (item.range_low != '0) && (item.range_low <= item.range_high) &&
                    (item.range_high <= n_active);

  always_comb begin
    cmd.lo    = item.range_low;
    cmd.hi    = item.range_high;
    cmd.pos   = item.position;
    cmd.value = item.new_value;
    if (item.kind == rmst_pkg::KIND_UPDATE) begin
      cmd.op = rmst_pkg::OP_UPDATE;
    end else if (range_ok) begin
      cmd.op = rmst_pkg::OP_QUERY;
    end else begin
      cmd.op = rmst_pkg::OP_REJECT;
    end
  end

  // out-of-range updates are dropped here
  assign push = accept & ((item.kind != rmst_pkg::KIND_UPDATE) | pos_ok);

endmodule

// ----- hdl/rmst_queue.sv -----
module rmst_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rmst_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           q_valid,
  output logic           q_full,
  output rmst_pkg::cmd_t head
);

  rmst_pkg::cmd_t              slots [rmst_pkg::QDEPTH];
  logic [rmst_pkg::QPTR_W-1:0] wr_ptr;
  logic [rmst_pkg::QPTR_W-1:0] rd_ptr;
  logic [rmst_pkg::QCNT_W-1:0] count;
  logic                        do_pop;

  assign q_valid = (count != '0);
  assign q_full  = (count == rmst_pkg::QCNT_W'(rmst_pkg::QDEPTH));
  assign head    = slots[rd_ptr];
  assign do_pop  = pop & q_valid;

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/rmst_back.sv -----
module rmst_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  rmst_pkg::cmd_t     head,
  output logic               pop,
  output logic               clearing,
  output rmst_pkg::out_word_t result,
  output logic               result_valid
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF,
    ST_UP,
    ST_WALK
  } state_t;

  localparam int NW = rmst_pkg::NODE_W;
  localparam int WW = rmst_pkg::WALK_W;
  localparam int VW = rmst_pkg::VALUE_W;

  state_t                state;
  logic signed [VW-1:0]  tree [2 * rmst_pkg::MaxLeaves];
  logic [NW-1:0]         clr_cnt;
  logic [NW-1:0]         node;
  logic signed [VW-1:0]  cur;
  logic [WW-1:0]         a;
  logic [WW-1:0]         b;
  logic signed [VW-1:0]  best;
  logic                  pend_a;
  logic                  pend_b;
  logic signed [VW-1:0]  rd_a;
  logic signed [VW-1:0]  rd_b;

  logic                  mem_we;
  logic [NW-1:0]         mem_wa;
  logic signed [VW-1:0]  mem_wd;
  logic [NW-1:0]         ra_addr;
  logic [NW-1:0]         rb_addr;
  logic [NW-1:0]         parent;
  logic signed [VW-1:0]  up_val;
  logic signed [VW-1:0]  best_a;
  logic signed [VW-1:0]  best_next;
  logic [WW-1:0]         b_m1;
  logic                  walking;
  logic                  take_a;
  logic                  take_b;

  // tree store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tree[mem_wa] <= mem_wd;
    end
    rd_a <= tree[ra_addr];
    rd_b <= tree[rb_addr];
  end

  assign parent    = node >> 1;
  assign up_val    = rmst_pkg::smax(cur, rd_a);
  assign best_a    = pend_a ? rmst_pkg::smax(best, rd_a) : best;
  assign best_next = pend_b ? rmst_pkg::smax(best_a, rd_b) : best_a;
  assign b_m1      = b - 1'b1;
  assign walking   = (a < b);
  assign take_a    = (state == ST_WALK) & walking & a[0];
  assign take_b    = (state == ST_WALK) & walking & b[0];
  assign pop       = (state == ST_IDLE) & q_valid;
  assign clearing  = (state == ST_CLEAR);

  // memory port steering
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = node;
    mem_wd  = cur;
    ra_addr = a[NW-1:0];
    rb_addr = b_m1[NW-1:0];
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
        mem_wd = rmst_pkg::MostNeg;
      end
      ST_LEAF: begin
        mem_we  = 1'b1;
        ra_addr = node ^ NW'(1);
      end
      ST_UP: begin
        mem_we  = 1'b1;
        mem_wa  = parent;
        mem_wd  = up_val;
        ra_addr = parent ^ NW'(1);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
      pend_a       <= 1'b0;
      pend_b       <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            case (head.op)
              rmst_pkg::OP_UPDATE: begin
                node  <= NW'(rmst_pkg::MaxLeaves) + NW'(head.pos) - NW'(1);
                cur   <= head.value;
                state <= ST_LEAF;
              end
              rmst_pkg::OP_QUERY: begin
                a      <= WW'(rmst_pkg::MaxLeaves) + WW'(head.lo) - WW'(1);
                b      <= WW'(rmst_pkg::MaxLeaves) + WW'(head.hi);
                best   <= rmst_pkg::MostNeg;
                pend_a <= 1'b0;
                pend_b <= 1'b0;
                state  <= ST_WALK;
              end
              default: begin
                result.max_value   <= '0;
                result.range_error <= 1'b1;
                result_valid       <= 1'b1;
              end
            endcase
          end
        end
        ST_LEAF: begin
          state <= ST_UP;
        end
        ST_UP: begin
          node <= parent;
          cur  <= up_val;
          if (parent == NW'(1)) begin
            state <= ST_IDLE;
          end
        end
        ST_WALK: begin
          // issue reads for this level, fold in last level's data
          best   <= best_next;
          pend_a <= take_a;
          pend_b <= take_b;
          if (walking) begin
            a <= (a + WW'(take_a)) >> 1;
            b <= (b - WW'(take_b)) >> 1;
          end else begin
            result.max_value   <= best_next;
            result.range_error <= 1'b0;
            result_valid       <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- verif/range_max_segment_tree_test.sv -----
module range_max_segment_tree_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 10000; // several times the store sweep after reset
  localparam int SETTLE_CYCLES = 64;    // engine plus two queued commands
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_ITEMS   = 165;
  localparam logic signed [rmst_pkg::VALUE_W-1:0] MaxPos =
    {1'b0, {(rmst_pkg::VALUE_W-1){1'b1}}};

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  rmst_pkg::in_word_t item;
  logic cfg_we;
  logic [rmst_pkg::LEAF_W-1:0] cfg_data;
  rmst_pkg::out_word_t result;
  logic result_valid;

  // shadow copy of the block state
  logic signed [rmst_pkg::VALUE_W-1:0] shadow_tree [2*rmst_pkg::MaxLeaves];
  logic [rmst_pkg::LEAF_W-1:0] leaf_count_shadow;

  rmst_pkg::out_word_t expected_max_q [$];
  rmst_pkg::out_word_t head_word;
  int fail_count = 0;
  int idle_cycles = 0;
  int idle_pct = 26;

  range_max_segment_tree u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .result       (result),
    .result_valid (result_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // leaf_count above the tree size behaves as the tree size
  function automatic int active_leaf_count();
    return (leaf_count_shadow > rmst_pkg::MaxLeaves) ? rmst_pkg::MaxLeaves :
           int'(leaf_count_shadow);
  endfunction

  // point write, then rebuild maxima up to the root
  function automatic void tree_write(input int pos,
                                     input logic signed [rmst_pkg::VALUE_W-1:0] val);
    int i;
    if (pos < 1 || pos > active_leaf_count()) return;
    i = rmst_pkg::MaxLeaves + pos - 1;
    shadow_tree[i] = val;
    while (i > 1) begin
      i = i >> 1;
      shadow_tree[i] = (shadow_tree[2*i] >= shadow_tree[2*i+1]) ?
                       shadow_tree[2*i] : shadow_tree[2*i+1];
    end
  endfunction

  // bottom-up walk over the half-open leaf span
  function automatic rmst_pkg::out_word_t tree_range_max(input int lo, input int hi);
    rmst_pkg::out_word_t r;
    int a;
    int b;
    logic signed [rmst_pkg::VALUE_W-1:0] best;
    r.max_value   = '0;
    r.range_error = 1'b1;
    if (lo < 1 || lo > hi || hi > active_leaf_count()) return r;
    a = rmst_pkg::MaxLeaves + lo - 1;
    b = rmst_pkg::MaxLeaves + hi;
    best = rmst_pkg::MostNeg;
    while (a < b) begin
      if (a[0]) begin
        if (shadow_tree[a] > best) best = shadow_tree[a];
        a++;
      end
      if (b[0]) begin
        b--;
        if (shadow_tree[b] > best) best = shadow_tree[b];
      end
      a = a >> 1;
      b = b >> 1;
    end
    r.max_value   = best;
    r.range_error = 1'b0;
    return r;
  endfunction

  task automatic note_mismatch(input string what,
                               input logic [rmst_pkg::VALUE_W-1:0] exp_v,
                               input logic [rmst_pkg::VALUE_W-1:0] act_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("mismatch %s: expected %h got %h", what, exp_v, act_v);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_max_q.size() == 0) begin
        note_mismatch("unexpected word", '0, result.max_value);
      end else begin
        head_word = expected_max_q.pop_front();
        if (result.max_value !== head_word.max_value)
          note_mismatch("max_value", head_word.max_value, result.max_value);
        if (result.range_error !== head_word.range_error)
          note_mismatch("range_error", rmst_pkg::VALUE_W'(head_word.range_error),
                        rmst_pkg::VALUE_W'(result.range_error));
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // send one word, predict, then maybe idle a while
  task automatic send_word(input rmst_pkg::in_word_t w);
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy);
    if (w.kind == rmst_pkg::KIND_UPDATE)
      tree_write(int'(w.position), w.new_value);
    else
      expected_max_q.push_back(tree_range_max(int'(w.range_low), int'(w.range_high)));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drive_query(input int lo, input int hi);
    rmst_pkg::in_word_t w;
    w = rmst_pkg::in_word_t'({$urandom, $urandom, $urandom});
    w.kind       = rmst_pkg::KIND_QUERY;
    w.range_low  = lo[rmst_pkg::LEAF_W-1:0];
    w.range_high = hi[rmst_pkg::LEAF_W-1:0];
    send_word(w);
  endtask

  task automatic drive_update(input int pos,
                              input logic signed [rmst_pkg::VALUE_W-1:0] val);
    rmst_pkg::in_word_t w;
    w = rmst_pkg::in_word_t'({$urandom, $urandom, $urandom});
    w.kind      = rmst_pkg::KIND_UPDATE;
    w.position  = pos[rmst_pkg::LEAF_W-1:0];
    w.new_value = val;
    send_word(w);
  endtask

  task automatic wait_results_done();
    start <= 1'b0;
    @(posedge clk);
    while (expected_max_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_leaf_count(input int count);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= count[rmst_pkg::LEAF_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    leaf_count_shadow = count[rmst_pkg::LEAF_W-1:0];
  endtask

  // mostly well-formed words for the current leaf count, some raw noise
  function automatic rmst_pkg::in_word_t make_random_word();
    rmst_pkg::in_word_t w;
    int n;
    int lo;
    int hi;
    int roll;
    n = active_leaf_count();
    w = rmst_pkg::in_word_t'({$urandom, $urandom, $urandom});
    roll = $urandom_range(99);
    if (roll < 10 || n == 0) return w;
    if (roll < 55) begin
      w.kind     = rmst_pkg::KIND_UPDATE;
      w.position = rmst_pkg::LEAF_W'($urandom_range(n, 1));
      case ($urandom_range(3))
        1: w.new_value = int'($urandom_range(2000)) - 1000;
        2: w.new_value = $urandom_range(1) ? MaxPos : rmst_pkg::MostNeg;
        default: w.new_value = $urandom;
      endcase
    end else begin
      w.kind = rmst_pkg::KIND_QUERY;
      lo = $urandom_range(n, 1);
      case ($urandom_range(3))
        0: hi = lo;
        1: hi = (lo + int'($urandom_range(15)) > n) ? n : lo + int'($urandom_range(15));
        2: hi = $urandom_range(n, lo);
        default: begin
          lo = 1;
          hi = n;
        end
      endcase
      w.range_low  = lo[rmst_pkg::LEAF_W-1:0];
      w.range_high = hi[rmst_pkg::LEAF_W-1:0];
    end
    return w;
  endfunction

  // queries straight after reset see only the cleared store
  task automatic test_empty_tree();
    drive_query(1, rmst_pkg::MaxLeaves);
    drive_query(rmst_pkg::MaxLeaves, rmst_pkg::MaxLeaves);
  endtask

  task automatic test_directed_cases();
    write_leaf_count(rmst_pkg::MaxLeaves);
    drive_update(1, MaxPos);
    drive_update(rmst_pkg::MaxLeaves, rmst_pkg::MostNeg);
    drive_update(512, -1000);
    drive_query(1, 1);
    drive_query(1, rmst_pkg::MaxLeaves);
    drive_query(2, rmst_pkg::MaxLeaves);
    drive_query(513, rmst_pkg::MaxLeaves);   // unwritten positions and the leaf set to the most negative value only
    drive_query(512, 512);
    // rejected ranges
    drive_query(0, 5);
    drive_query(6, 5);
    drive_query(1, rmst_pkg::MaxLeaves + 1);
    drive_query(2047, 2047);
    // updates out of range are dropped
    drive_update(0, 7);
    drive_update(rmst_pkg::MaxLeaves + 1, 7);
    drive_update(2047, MaxPos);
    drive_query(2, rmst_pkg::MaxLeaves);
    // zero leaves: all rejected or dropped
    write_leaf_count(0);
    drive_query(1, 1);
    drive_update(1, 3);
    drive_query(0, 0);
    // oversized count clamps to the tree size
    write_leaf_count(2047);
    drive_query(1, rmst_pkg::MaxLeaves);
    drive_query(1, rmst_pkg::MaxLeaves + 1);
    drive_update(rmst_pkg::MaxLeaves, 5);
    // shrinking keeps stored values in place
    write_leaf_count(3);
    drive_query(1, 3);
    drive_query(rmst_pkg::MaxLeaves, rmst_pkg::MaxLeaves);
  endtask

  // build a small tree in order, then query it
  task automatic test_ordered_build();
    int n;
    int lo;
    n = $urandom_range(24, 1);
    write_leaf_count(n);
    for (int p = 1; p <= n; p++) drive_update(p, $urandom);
    for (int k = 0; k < 10; k++) begin
      lo = $urandom_range(n, 1);
      drive_query(lo, $urandom_range(n, lo));
    end
  endtask

  function automatic int phase_leaves(input int ph);
    case (ph)
      0: return 1024;
      1: return 1;
      2: return 37;
      3: return 0;
      4: return 2047;
      5: return 2;
      6: return 600;
      7: return 1024;
      default: return 16;
    endcase
  endfunction

  task automatic test_random_traffic();
    int count;
    for (int ph = 0; ph < 9; ph++) begin
      write_leaf_count(phase_leaves(ph));
      idle_pct = (ph < 3) ? 26 : (ph < 6) ? 80 : 0;
      count = (phase_leaves(ph) == 0) ? 40 : PHASE_ITEMS;
      for (int k = 0; k < count; k++) begin
        // hold off once until the block has answered everything
        if (ph == 1 && k == count / 2) wait_results_done();
        send_word(make_random_word());
      end
    end
  endtask

  initial begin
    foreach (shadow_tree[i]) shadow_tree[i] = rmst_pkg::MostNeg;
    leaf_count_shadow = rmst_pkg::MaxLeaves;
    rst      <= 1'b1;
    start    <= 1'b0;
    item     <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_empty_tree();
    test_directed_cases();
    test_ordered_build();
    test_random_traffic();

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_max_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
